// ===== hdl/linear_probe_hash_table_macros.svh =====
// Assertion macros for the linear probe hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Overlapping implication, sampled on clk, off during reset.
`define LPHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Implication into the next cycle.
`define LPHT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Invariant.
`define LPHT_ASSERT_ALW(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

`endif

// ===== hdl/lpht_pkg.sv =====
// Shared constants and types of the linear probe hash table.
package lpht_pkg;

    localparam int SLOTS   = 256;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int LIMIT_W = 9;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 64;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd192;
    localparam logic [0:0]         REG_LOAD_LIMIT = 1'b0;

    localparam logic [1:0] ACT_SET = 2'd0;
    localparam logic [1:0] ACT_GET = 2'd1;
    localparam logic [1:0] ACT_DEL = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              key_we;
        logic              val_we;
        logic [SLOT_W-1:0] wr_addr;
        logic              wr_tomb;
        logic [KEY_W-1:0]  wr_key;
        logic [VAL_W-1:0]  wr_value;
    } store_req_t;

    typedef struct packed {
        logic             valid;
        logic             tomb;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } store_rsp_t;

endpackage

// ===== hdl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table.
// Request channel (in_valid/in_ready): action, key_id, key_hash, value_in.
// Actions: set, get, delete; the unused fourth code answers not found.
// Response channel (out_valid/out_ready): status, value_out, one beat per request.
// The table has SLOTS entries; probing starts at key_hash masked to the slot
// count and steps one slot per cycle until a key match, an empty slot or a full lap.
// One request is handled at a time: up to SLOTS slots are probed in turn, then
// the result is loaded into the output register, which raises out_valid, and
// only then is the next request taken; the load waits while the output
// register still holds a beat that has not been taken.
// The probe rate is set by the single read port of the slot memories.
// The response waits in an output register; a stalled receiver holds it there
// while the next request is already probed, and a second result waits until
// the first beat is taken.
// Reset empties every slot, clears the use count and sets load_limit to 192.
// load_limit sits at APB byte address 0; the user must write it only while idle, the block does not enforce this.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [KEY_W-1:0]  key_id,
    input  logic [31:0]       key_hash,
    input  logic [VAL_W-1:0]  value_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [VAL_W-1:0]  value_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [LIMIT_W-1:0] load_limit;
    store_req_t         req;
    store_rsp_t         rsp;

    lpht_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .load_limit (load_limit)
    );

    lpht_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    lpht_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .key_id     (key_id),
        .key_hash   (key_hash),
        .value_in   (value_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .value_out  (value_out),
        .load_limit (load_limit),
        .req        (req),
        .rsp        (rsp)
    );

endmodule

// ===== hdl/lpht_regs.sv =====
// APB register file: load limit.
module lpht_regs
    import lpht_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [LIMIT_W-1:0] load_limit
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_LOAD_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_hit)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[ADDR_W-1] == REG_LOAD_LIMIT)
        begin
            prdata = DATA_W'(limit_reg);
        end
    end

    assign load_limit = limit_reg;

endmodule

// ===== hdl/lpht_store.sv =====
// Slot storage: key/tombstone memory, value memory, per-slot written bits.
module lpht_store
    import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output store_rsp_t rsp
);

    logic [KEY_W:0]   key_mem [SLOTS];
    logic [VAL_W-1:0] val_mem [SLOTS];
    logic [SLOTS-1:0] written_reg;
    logic [KEY_W:0]   key_q_reg;
    logic [VAL_W-1:0] val_q_reg;
    logic             written_q_reg;

    // written bit: slot ever held a key; unwritten slots read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
        end
        else
        begin
            if (req.key_we)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                written_q_reg <= written_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.key_we)
        begin
            key_mem[req.wr_addr] <= {req.wr_tomb, req.wr_key};
        end
        if (req.rd_en)
        begin
            key_q_reg <= key_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.val_we)
        begin
            val_mem[req.wr_addr] <= req.wr_value;
        end
        if (req.rd_en)
        begin
            val_q_reg <= val_mem[req.rd_addr];
        end
    end

    assign rsp.valid = written_q_reg;
    assign rsp.tomb  = key_q_reg[KEY_W];
    assign rsp.key   = key_q_reg[KEY_W-1:0];
    assign rsp.value = val_q_reg;

endmodule

// ===== hdl/lpht_ctrl.sv =====
// Probe sequencer: walks slots, decides the action, writes back, holds the result.
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [KEY_W-1:0]   key_id,
    input  logic [31:0]        key_hash,
    input  logic [VAL_W-1:0]   value_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [VAL_W-1:0]   value_out,
    input  logic [LIMIT_W-1:0] load_limit,
    output store_req_t         req,
    input  store_rsp_t         rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        act_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] cnt_reg;
    logic              have_tomb_reg;
    logic [SLOT_W-1:0] tomb_idx_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [2:0]        res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [VAL_W-1:0]  out_value_reg;

    logic              accept;
    logic              hit, is_tomb, is_empty, last, stop;
    logic              tomb_seen, have_slot;
    logic [SLOT_W-1:0] tomb_at, slot_idx;
    logic              room;
    logic              count_up;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign hit       = rsp.valid && !rsp.tomb && (rsp.key == key_reg);
    assign is_tomb   = rsp.valid && rsp.tomb;
    assign is_empty  = !rsp.valid;
    assign last      = &cnt_reg;
    assign stop      = hit || is_empty || last;
    assign tomb_seen = have_tomb_reg || is_tomb;
    assign tomb_at   = have_tomb_reg ? tomb_idx_reg : idx_reg;
    assign have_slot = is_empty || tomb_seen;
    assign slot_idx  = tomb_seen ? tomb_at : idx_reg;
    assign room      = CMP_W'(used_reg) < CMP_W'(load_limit);

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        count_up        = 1'b0;
        req             = '0;
        req.wr_key      = key_reg;
        req.wr_value    = val_reg;
        req.wr_addr     = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req.rd_addr = key_hash[SLOT_W-1:0];
                if (accept)
                begin
                    if (action == ACT_SET || action == ACT_GET || action == ACT_DEL)
                    begin
                        req.rd_en  = 1'b1;
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_value_next  = '0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_PROBE:
            begin
                req.rd_addr = idx_reg + 1'b1;
                if (!stop)
                begin
                    req.rd_en = 1'b1;
                end
                else
                begin
                    state_next      = S_DONE;
                    res_status_next = ST_NOT_FOUND;
                    res_value_next  = '0;
                    priority case (act_reg)
                        ACT_SET:
                        begin
                            if (hit)
                            begin
                                req.val_we      = 1'b1;
                                res_status_next = ST_UPDATED;
                            end
                            else if (!have_slot)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (tomb_seen || room)
                            begin
                                req.wr_addr     = slot_idx;
                                req.key_we      = 1'b1;
                                req.val_we      = 1'b1;
                                count_up        = !tomb_seen;
                                res_status_next = ST_INSERTED;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        ACT_GET:
                        begin
                            if (hit)
                            begin
                                res_status_next = ST_FOUND;
                                res_value_next  = rsp.value;
                            end
                        end
                        default:
                        begin
                            if (hit)
                            begin
                                req.key_we      = 1'b1;
                                req.wr_tomb     = 1'b1;
                                res_status_next = ST_DELETED;
                            end
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                req.rd_addr = idx_reg;
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                req.rd_addr = idx_reg;
                state_next  = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            have_tomb_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (count_up)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (accept)
            begin
                have_tomb_reg <= 1'b0;
            end
            else if (state_reg == S_PROBE && is_tomb)
            begin
                have_tomb_reg <= 1'b1;
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (accept)
        begin
            act_reg <= action;
            key_reg <= key_id;
            val_reg <= value_in;
            idx_reg <= key_hash[SLOT_W-1:0];
            cnt_reg <= '0;
        end
        else if (state_reg == S_PROBE && !stop)
        begin
            idx_reg <= idx_reg + 1'b1;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == S_PROBE && is_tomb && !have_tomb_reg)
        begin
            tomb_idx_reg <= idx_reg;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign value_out = out_value_reg;

endmodule

// ===== hdl/lpht_checker.sv =====
// Port-level checker for the linear probe hash table, bound to the top level.
`include "linear_probe_hash_table_macros.svh"

module lpht_checker
    import lpht_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        action,
    input logic [KEY_W-1:0]  key_id,
    input logic [31:0]       key_hash,
    input logic [VAL_W-1:0]  value_in,
    input logic              out_valid,
    input logic              out_ready,
    input logic [2:0]        status,
    input logic [VAL_W-1:0]  value_out,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    `LPHT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(value_out))
    `LPHT_ASSERT_IMP(a_status_code, out_valid, status <= ST_FULL)
    `LPHT_ASSERT_IMP(a_value_zero, out_valid && status != ST_FOUND, value_out == '0)
    `LPHT_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
    `LPHT_ASSERT_ALW(a_pready, pready)

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

// ===== tb/sv/linear_probe_hash_table_tb.sv =====
// Self-checking testbench: directed and random set/get/delete traffic against a behavioral table.
module linear_probe_hash_table_tb;
    import lpht_pkg::*;

    localparam logic [1:0]        ACT_UNUSED  = 2'd3;
    localparam logic [ADDR_W-1:0] LIMIT_ADDR  = ADDR_W'(REG_LOAD_LIMIT) << 2;
    localparam int                CYCLE_LIMIT = 2_000_000;
    localparam int                IDLE_PCT    = 18;

    typedef enum logic [1:0] {SLOT_EMPTY, SLOT_LIVE, SLOT_TOMB} slot_tag_e;

    typedef struct packed {
        logic [2:0]       status;
        logic [VAL_W-1:0] value;
    } lookup_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        action = '0;
    logic [KEY_W-1:0]  key_id = '0;
    logic [31:0]       key_hash = '0;
    logic [VAL_W-1:0]  value_in = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        status;
    logic [VAL_W-1:0]  value_out;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // behavioral copy of the table
    slot_tag_e          tbl_tag [SLOTS];
    logic [KEY_W-1:0]   tbl_key [SLOTS];
    logic [VAL_W-1:0]   tbl_val [SLOTS];
    logic [CNT_W-1:0]   tbl_count;
    logic [LIMIT_W-1:0] tbl_limit;

    lookup_result_t pending_results [$];

    logic [KEY_W-1:0] pool_key  [128];
    logic [31:0]      pool_hash [128];

    int  error_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  steady_run = 1'b0;

    linear_probe_hash_table u_dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random back-pressure, long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic void flag_mismatch(string what, logic [VAL_W-1:0] want,
                                          logic [VAL_W-1:0] got);
        if (error_count < 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
        error_count++;
    endfunction

    always @(posedge clk)
    begin : check_results
        lookup_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result beat with nothing pending", '0, value_out);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", VAL_W'(want.status), VAL_W'(status));
                if (value_out !== want.value)
                    flag_mismatch("value_out", want.value, value_out);
            end
        end
    end

    function automatic lookup_result_t probe_and_update(logic [1:0] act, logic [KEY_W-1:0] key,
                                                        logic [31:0] hash, logic [VAL_W-1:0] val);
        lookup_result_t res;
        int idx;
        int n;
        int tomb_idx;
        int hit_idx;
        int empty_idx;
        int ins_idx;
        res.status = ST_NOT_FOUND;
        res.value = '0;
        if (act == ACT_UNUSED)
            return res;
        idx = int'(hash[SLOT_W-1:0]);
        tomb_idx = -1;
        hit_idx = -1;
        empty_idx = -1;
        for (n = 0; n < SLOTS; n++)
        begin
            if (hit_idx < 0 && empty_idx < 0)
            begin
                if (tbl_tag[idx] == SLOT_LIVE)
                begin
                    if (tbl_key[idx] == key)
                        hit_idx = idx;
                end
                else if (tbl_tag[idx] == SLOT_TOMB)
                begin
                    if (tomb_idx < 0)
                        tomb_idx = idx;
                end
                else
                    empty_idx = idx;
                idx = (idx + 1) % SLOTS;
            end
        end
        case (act)
            ACT_SET:
            begin
                ins_idx = -1;
                if (hit_idx >= 0)
                begin
                    tbl_val[hit_idx] = val;
                    res.status = ST_UPDATED;
                end
                else if (tomb_idx >= 0)
                    ins_idx = tomb_idx;
                else if (empty_idx < 0 || int'(tbl_count) + 1 > int'(tbl_limit))
                    res.status = ST_FULL;
                else
                begin
                    ins_idx = empty_idx;
                    tbl_count++;
                end
                if (ins_idx >= 0)
                begin
                    tbl_tag[ins_idx] = SLOT_LIVE;
                    tbl_key[ins_idx] = key;
                    tbl_val[ins_idx] = val;
                    res.status = ST_INSERTED;
                end
            end
            ACT_GET:
            begin
                if (hit_idx >= 0)
                begin
                    res.status = ST_FOUND;
                    res.value = tbl_val[hit_idx];
                end
            end
            default:
            begin
                if (hit_idx >= 0)
                begin
                    tbl_tag[hit_idx] = SLOT_TOMB;
                    res.status = ST_DELETED;
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [31:0] hash_at(int slot);
        logic [31:0] h;
        h = $urandom();
        h[SLOT_W-1:0] = SLOT_W'(slot % SLOTS);
        return h;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int count_tombstones();
        int n;
        int total;
        total = 0;
        for (n = 0; n < SLOTS; n++)
            if (tbl_tag[n] == SLOT_TOMB)
                total++;
        return total;
    endfunction

    // valid is left high after a beat so back-to-back requests never toggle it
    task automatic send_request(logic [1:0] act, logic [KEY_W-1:0] key, logic [31:0] hash,
                                logic [VAL_W-1:0] val);
        if (!steady_run && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        key_id <= key;
        key_hash <= hash;
        value_in <= val;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(probe_and_update(act, key, hash, val));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_load_limit(logic [LIMIT_W-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= LIMIT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[LIMIT_W-1:0] !== want)
            flag_mismatch("load_limit read", VAL_W'(want), VAL_W'(prdata[LIMIT_W-1:0]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write, then read back through a back-to-back transfer
    task automatic write_load_limit(int limit);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= DATA_W'(limit);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tbl_limit = LIMIT_W'(limit);
        check_load_limit(LIMIT_W'(limit));
    endtask

    task automatic test_register_reset();
        check_load_limit(LIMIT_RESET);
    endtask

    task automatic test_basic_actions();
        send_request(ACT_GET, 32'h0, 32'h0, rand_value());
        send_request(ACT_DEL, 32'h0, 32'h0, rand_value());
        send_request(ACT_SET, 32'h0, 32'h0, 64'h0);
        send_request(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        // collides at the top slot and wraps past slot zero
        send_request(ACT_SET, 32'h1, 32'h0000_00FF, 64'h0123_4567_89AB_CDEF);
        send_request(ACT_GET, 32'h1, 32'h0000_00FF, rand_value());
        send_request(ACT_SET, 32'h0, 32'h0, 64'h5555_5555_5555_5555);
        send_request(ACT_GET, 32'h0, 32'h0, rand_value());
        send_request(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand_value());
        send_request(ACT_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand_value());
        send_request(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand_value());
        send_request(ACT_GET, 32'h1, 32'h0000_00FF, rand_value());
        send_request(ACT_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand_value());
        // new key lands in the tombstone
        send_request(ACT_SET, 32'h1234, 32'h0000_00FF, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACT_UNUSED, 32'h1, 32'h0000_00FF, rand_value());
        send_request(ACT_SET, 32'h1, 32'h0000_00FF, 64'hAAAA_0000_5555_FFFF);
        send_request(ACT_DEL, 32'h1, 32'h0000_00FF, rand_value());
        send_request(ACT_SET, 32'h1, 32'h0000_00FF, rand_value());
        send_request(ACT_GET, 32'h1234, 32'h0000_00FF, rand_value());
    endtask

    task automatic test_load_limit_extremes();
        wait_idle();
        write_load_limit(0);
        send_request(ACT_SET, 32'hC0DE_0001, hash_at(100), rand_value());
        send_request(ACT_DEL, 32'h1234, 32'h0000_00FF, rand_value());
        send_request(ACT_SET, 32'hC0DE_0002, 32'h0000_00FF, rand_value());
        send_request(ACT_SET, 32'hC0DE_0002, 32'h0000_00FF, rand_value());
        wait_idle();
        write_load_limit(1);
        send_request(ACT_SET, 32'hC0DE_0003, hash_at(100), rand_value());
        send_request(ACT_GET, 32'hC0DE_0002, 32'h0000_00FF, rand_value());
    endtask

    task automatic fill_pool(int pool_n);
        int i;
        int base;
        base = $urandom_range(0, SLOTS - 1);
        for (i = 0; i < pool_n; i++)
        begin
            pool_key[i] = $urandom();
            pool_hash[i] = hash_at(base + $urandom_range(0, 23));
        end
    endtask

    task automatic test_random_traffic(int n_items, int limit, int pool_n, bit with_pressure);
        int n;
        int i;
        int pick;
        logic [1:0] act;
        logic [KEY_W-1:0] k;
        logic [31:0] h;
        wait_idle();
        write_load_limit(limit);
        fill_pool(pool_n);
        for (n = 0; n < n_items; n++)
        begin
            if (with_pressure && n == n_items / 3)
                stall_left = 400;
            steady_run = with_pressure && n >= n_items / 2 && n < n_items / 2 + 150;
            pick = $urandom_range(99);
            i = $urandom_range(0, pool_n - 1);
            k = pool_key[i];
            h = pool_hash[i];
            if (pick < 3)
                act = ACT_UNUSED;
            else if (pick < 43)
                act = ACT_SET;
            else if (pick < 75)
                act = ACT_GET;
            else
                act = ACT_DEL;
            if ($urandom_range(99) < 8)
            begin
                k = $urandom();
                h = $urandom();
            end
            send_request(act, k, h, rand_value());
        end
        steady_run = 1'b0;
    endtask

    task automatic test_full_table();
        int sweep;
        int victim;
        wait_idle();
        write_load_limit(SLOTS);
        sweep = $urandom_range(0, SLOTS - 1);
        while (int'(tbl_count) < SLOTS || count_tombstones() > 0)
        begin
            send_request(ACT_SET, $urandom(), hash_at(sweep), rand_value());
            sweep = (sweep + 1) % SLOTS;
        end
        // no empty slot left: every miss walks the whole table
        send_request(ACT_SET, $urandom(), hash_at($urandom_range(0, SLOTS - 1)), rand_value());
        send_request(ACT_GET, $urandom(), hash_at($urandom_range(0, SLOTS - 1)), rand_value());
        send_request(ACT_DEL, $urandom(), hash_at($urandom_range(0, SLOTS - 1)), rand_value());
        victim = $urandom_range(0, SLOTS - 1);
        send_request(ACT_DEL, tbl_key[victim], hash_at(victim), rand_value());
        send_request(ACT_GET, tbl_key[victim], hash_at(victim), rand_value());
        send_request(ACT_SET, $urandom(), hash_at(victim + 1), rand_value());
        send_request(ACT_SET, $urandom(), hash_at(victim), rand_value());
        send_request(ACT_SET, tbl_key[victim], hash_at(victim), rand_value());
    endtask

    task automatic test_saturated_traffic(int n_items);
        int n;
        int slot;
        int pick;
        logic [1:0] act;
        logic [KEY_W-1:0] k;
        logic [31:0] h;
        wait_idle();
        for (n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            act = (pick < 35) ? ACT_SET : (pick < 65) ? ACT_GET : ACT_DEL;
            slot = $urandom_range(0, SLOTS - 1);
            if (tbl_tag[slot] == SLOT_LIVE && $urandom_range(99) < 80)
            begin
                k = tbl_key[slot];
                h = hash_at(slot + SLOTS - $urandom_range(0, 3));
            end
            else
            begin
                k = $urandom();
                h = hash_at(slot);
            end
            send_request(act, k, h, rand_value());
        end
    endtask

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
            tbl_tag[s] = SLOT_EMPTY;
        tbl_count = '0;
        tbl_limit = LIMIT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_basic_actions();
        test_load_limit_extremes();
        test_random_traffic(200, int'(tbl_count) + 20, 40, 1'b0);
        test_random_traffic(400, LIMIT_RESET, 96, 1'b1);
        test_full_table();
        test_saturated_traffic(150);

        wait_idle();
        repeat (SLOTS + 4) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
